>>> design/kski_pkg.sv
// ----------------------------------------------------------------------------
// kski_pkg - shared types and constants of the keyframe sky interpolator
// Field widths, function codes, register indexes and the sun direction table.
// ----------------------------------------------------------------------------
package kski_pkg;

  // sizes
  localparam int MAX_KEYS         = 8;
  localparam int KEY_IDX_W        = $clog2(MAX_KEYS);
  localparam int CNT_W            = 4;
  localparam int TIME_BITS        = 16;
  localparam int SPAN_W           = TIME_BITS + 1;
  localparam int CHAN_W           = 16;
  localparam int NUM_CHAN         = 6;
  localparam int VAL_W            = NUM_CHAN * CHAN_W;
  localparam int ENTRY_W          = TIME_BITS + VAL_W;
  localparam int FRAC_BITS        = 16;
  localparam int DIV_STAGES       = FRAC_BITS;
  localparam int SINE_TABLE_DEPTH = 256;
  localparam int SINE_BITS        = $clog2(SINE_TABLE_DEPTH);
  localparam int SUN_ENTRIES      = SINE_TABLE_DEPTH / 2 + 1;
  localparam int SUN_IDX_W        = $clog2(SUN_ENTRIES);
  localparam int SUN_FIXED_IDX    = SINE_TABLE_DEPTH / 2;
  localparam int SUN_W            = 3 * CHAN_W;

  // spans not above 1/10000 of a day give weight zero
  localparam logic [31:0] SHORT_SPAN_MUL = 32'd10000;
  localparam logic [31:0] TIME_ONE       = 32'(1) << TIME_BITS;

  // function codes of an input request
  typedef enum logic [1:0] {
    FUNC_WR_COLOR  = 2'd0,
    FUNC_WR_BRIGHT = 2'd1,
    FUNC_QUERY     = 2'd2,
    FUNC_RSVD      = 2'd3
  } func_e;

  // configuration register indexes
  localparam logic REG_COLOR_CNT  = 1'b0;
  localparam logic REG_BRIGHT_CNT = 1'b1;

  // per-track request control
  typedef struct packed {
    logic query;
    logic wr;
  } trk_ctl_t;

  typedef logic [SUN_W-1:0] sun_tab_t [SUN_ENTRIES];

  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam longint      Q14_ONE     = 16384;

  // shift and subtract quotient, used while building the sun table
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // sine of a Q30 quarter-turn fraction, Q14
  function automatic longint sin_quarter(logic [63:0] r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    x    = (r * PI_HALF_Q30) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 6; k++) begin
      term = udiv64((term * x2) >> 30, 64'((2 * k) * (2 * k + 1)));
      if ((k & 1) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    sum = longint'((64'(sum) + 64'd32768) >> 16);
    return (sum > Q14_ONE) ? Q14_ONE : sum;
  endfunction

  // sine of a Q32 full-turn phase, Q14
  function automatic longint sin_turn(logic [63:0] ph);
    logic [1:0]  q;
    logic [63:0] r;
    longint      v;
    q = ph[31:30];
    r = ph & 64'h3FFF_FFFF;
    if (q[0]) begin
      r = 64'h4000_0000 - r;
    end
    v = sin_quarter(r);
    return q[1] ? -v : v;
  endfunction

  function automatic logic [63:0] isqrt64(logic [63:0] val);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bitv;
    v    = val;
    res  = '0;
    bitv = 64'(1) << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // normalized sun vector {x, y, z}, Q1.14 each
  function automatic logic [SUN_W-1:0] sun_entry(int idx);
    longint      v [3];
    logic [63:0] ph;
    logic [63:0] len;
    logic [63:0] m;
    logic [63:0] q;
    logic [SUN_W-1:0] res;
    if (idx >= SUN_FIXED_IDX) begin
      v[0] = 3277;
      v[1] = 13107;
      v[2] = 4915;
    end else begin
      ph   = (64'(idx) << 32) >> SINE_BITS;
      v[0] = -sin_turn((ph + 64'h4000_0000) & 64'hFFFF_FFFF);
      v[1] = sin_turn(ph) + 1638;
      v[2] = 4915;
    end
    len = isqrt64(64'(v[0] * v[0] + v[1] * v[1] + v[2] * v[2]));
    if (len == 0) begin
      len = 64'd1;
    end
    res = '0;
    for (int k = 0; k < 3; k++) begin
      m = (v[k] < 0) ? 64'(-v[k]) : 64'(v[k]);
      q = udiv64(m * 64'(Q14_ONE) + (len >> 1), len);
      if (q > 64'(Q14_ONE)) begin
        q = 64'(Q14_ONE);
      end
      res[(2 - k) * CHAN_W +: CHAN_W] = (v[k] < 0) ? CHAN_W'(64'h10000 - q) : CHAN_W'(q);
    end
    return res;
  endfunction

  function automatic sun_tab_t build_sun_tab();
    sun_tab_t tab;
    for (int i = 0; i < SUN_ENTRIES; i++) begin
      tab[i] = sun_entry(i);
    end
    return tab;
  endfunction

  localparam sun_tab_t SUN_TAB = build_sun_tab();

endpackage

>>> design/kski_ram.sv
// ----------------------------------------------------------------------------
// kski_ram - generic RAM
// One write port and two registered read ports.
// ----------------------------------------------------------------------------
module kski_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered reads
  always_ff @(posedge clk_i) begin
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

>>> design/kski_track.sv
// ----------------------------------------------------------------------------
// kski_track - one keyframe track
// Key store, bracket search, pipelined span divide, smoothstep and blend.
// ----------------------------------------------------------------------------
module kski_track (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  kski_pkg::trk_ctl_t                             ctl_i,
  input  logic [kski_pkg::CNT_W-1:0]                     cnt_i,
  input  logic [kski_pkg::KEY_IDX_W-1:0]                 idx_i,
  input  logic [kski_pkg::TIME_BITS-1:0]                 t_i,
  input  logic [kski_pkg::VAL_W-1:0]                     vals_i,
  output logic                                           valid_o,
  output logic [kski_pkg::NUM_CHAN-1:0][kski_pkg::CHAN_W-1:0] res_o,
  output logic [kski_pkg::TIME_BITS-1:0]                 t_o
);
  import kski_pkg::*;

  typedef struct packed {
    logic                 empty;
    logic                 zerow;
    logic                 sat;
    logic [TIME_BITS-1:0] t;
    logic [VAL_W-1:0]     a;
    logic [VAL_W-1:0]     b;
  } pay_t;

  localparam int L = DIV_STAGES - 1;

  // ---- stage 1: key times, bracket search, table read
  logic [TIME_BITS-1:0] times_q [MAX_KEYS];
  logic [CNT_W-1:0]     n;
  logic [MAX_KEYS-1:0]  gt;
  logic [KEY_IDX_W-1:0] nx;
  logic [KEY_IDX_W-1:0] lo;
  logic [KEY_IDX_W-1:0] hi;
  logic [ENTRY_W-1:0]   rd_lo;
  logic [ENTRY_W-1:0]   rd_hi;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      times_q[idx_i] <= t_i;
    end
  end

  always_comb begin
    n = (cnt_i > CNT_W'(MAX_KEYS)) ? CNT_W'(MAX_KEYS) : cnt_i;
    for (int i = 0; i < MAX_KEYS; i++) begin
      gt[i] = (CNT_W'(i) < n) && (times_q[i] > t_i);
    end
    // first key later than the query time, else wrap to entry zero
    nx = '0;
    for (int i = MAX_KEYS - 1; i >= 0; i--) begin
      if (gt[i]) begin
        nx = KEY_IDX_W'(i);
      end
    end
    hi = nx;
    lo = (nx == '0) ? KEY_IDX_W'(n - CNT_W'(1)) : nx - KEY_IDX_W'(1);
    if (n == CNT_W'(1)) begin
      lo = '0;
      hi = '0;
    end
  end

  kski_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_KEYS)
  ) u_keys (
    .clk_i     (clk_i),
    .we_i      (ctl_i.wr),
    .waddr_i   (idx_i),
    .wdata_i   ({t_i, vals_i}),
    .raddr_a_i (lo),
    .rdata_a_o (rd_lo),
    .raddr_b_i (hi),
    .rdata_b_o (rd_hi)
  );

  logic                 v1_q;
  logic [TIME_BITS-1:0] t1_q;
  logic                 empty1_q;
  logic                 single1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= ctl_i.query;
    end
  end

  always_ff @(posedge clk_i) begin
    t1_q      <= t_i;
    empty1_q  <= (n == '0);
    single1_q <= (n == CNT_W'(1));
  end

  // ---- stage 2: span and local offset
  logic [TIME_BITS-1:0] k_t0;
  logic [TIME_BITS-1:0] k_t1;
  logic [SPAN_W-1:0]    span_d;
  logic [SPAN_W-1:0]    num_d;
  logic                 short_span;
  pay_t                 pay2_d;

  always_comb begin
    k_t0   = rd_lo[ENTRY_W-1 -: TIME_BITS];
    k_t1   = rd_hi[ENTRY_W-1 -: TIME_BITS];
    span_d = (k_t1 <= k_t0) ? SPAN_W'({1'b1, k_t1}) - SPAN_W'(k_t0)
                            : SPAN_W'(k_t1) - SPAN_W'(k_t0);
    num_d  = (t1_q < k_t0) ? SPAN_W'({1'b1, t1_q}) - SPAN_W'(k_t0)
                           : SPAN_W'(t1_q) - SPAN_W'(k_t0);
    short_span   = (32'(span_d) * SHORT_SPAN_MUL) <= TIME_ONE;
    pay2_d.empty = empty1_q;
    pay2_d.zerow = single1_q || short_span;
    pay2_d.sat   = num_d >= span_d;
    pay2_d.t     = t1_q;
    pay2_d.a     = rd_lo[VAL_W-1:0];
    pay2_d.b     = rd_hi[VAL_W-1:0];
  end

  logic              v2_q;
  pay_t              pay2_q;
  logic [SPAN_W-1:0] num2_q;
  logic [SPAN_W-1:0] span2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pay2_q  <= pay2_d;
    num2_q  <= num_d;
    span2_q <= span_d;
  end

  // ---- divide stages: one quotient bit each
  logic                 dv_q  [DIV_STAGES];
  pay_t                 dp_q  [DIV_STAGES];
  logic [SPAN_W-1:0]    rem_q [DIV_STAGES];
  logic [SPAN_W-1:0]    dsp_q [DIV_STAGES];
  logic [FRAC_BITS-1:0] quo_q [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    logic                 v_in;
    pay_t                 pay_in;
    logic [SPAN_W-1:0]    rem_in;
    logic [SPAN_W-1:0]    span_in;
    logic [FRAC_BITS-1:0] quo_in;
    logic [SPAN_W:0]      shl;
    logic                 ge;

    if (k == 0) begin : g_first
      assign v_in    = v2_q;
      assign pay_in  = pay2_q;
      assign rem_in  = num2_q;
      assign span_in = span2_q;
      assign quo_in  = '0;
    end else begin : g_next
      assign v_in    = dv_q[k-1];
      assign pay_in  = dp_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign span_in = dsp_q[k-1];
      assign quo_in  = quo_q[k-1];
    end

    assign shl = {rem_in, 1'b0};
    assign ge  = shl >= {1'b0, span_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= 1'b0;
      end else begin
        dv_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      dp_q[k]  <= pay_in;
      dsp_q[k] <= span_in;
      rem_q[k] <= ge ? SPAN_W'(shl - {1'b0, span_in}) : SPAN_W'(shl);
      quo_q[k] <= {quo_in[FRAC_BITS-2:0], ge};
    end
  end

  // ---- stage 3: square of the position and the linear factor 3 - 2s
  logic [FRAC_BITS:0]       s_pos;
  logic                     v3_q;
  pay_t                     pay3_q;
  logic [2*FRAC_BITS+1:0]   sq3_q;
  logic [FRAC_BITS+1:0]     w3_q;

  always_comb begin
    if (dp_q[L].zerow) begin
      s_pos = '0;
    end else if (dp_q[L].sat) begin
      s_pos = (FRAC_BITS+1)'(1) << FRAC_BITS;
    end else begin
      s_pos = {1'b0, quo_q[L]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= dv_q[L];
    end
  end

  always_ff @(posedge clk_i) begin
    pay3_q <= dp_q[L];
    sq3_q  <= (2*FRAC_BITS+2)'(s_pos) * (2*FRAC_BITS+2)'(s_pos);
    w3_q   <= ((FRAC_BITS+2)'(3) << FRAC_BITS) - ((FRAC_BITS+2)'(s_pos) << 1);
  end

  // ---- stage 4: smoothstep weight
  logic [3*FRAC_BITS+3:0] prod;
  logic                   v4_q;
  pay_t                   pay4_q;
  logic [FRAC_BITS:0]     f4_q;

  assign prod = (3*FRAC_BITS+4)'(sq3_q) * (3*FRAC_BITS+4)'(w3_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pay4_q <= pay3_q;
    f4_q   <= prod[2*FRAC_BITS +: FRAC_BITS+1];
  end

  // ---- stage 5: channel difference times weight
  localparam int M_W = CHAN_W + FRAC_BITS + 1;

  logic                    v5_q;
  pay_t                    pay5_q;
  logic [M_W-1:0]          m5_q  [NUM_CHAN];
  logic [NUM_CHAN-1:0]     ge5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pay5_q <= pay4_q;
    for (int c = 0; c < NUM_CHAN; c++) begin
      ge5_q[c] <= pay4_q.b[c*CHAN_W +: CHAN_W] >= pay4_q.a[c*CHAN_W +: CHAN_W];
      if (pay4_q.b[c*CHAN_W +: CHAN_W] >= pay4_q.a[c*CHAN_W +: CHAN_W]) begin
        m5_q[c] <= M_W'(pay4_q.b[c*CHAN_W +: CHAN_W] - pay4_q.a[c*CHAN_W +: CHAN_W])
                   * M_W'(f4_q);
      end else begin
        m5_q[c] <= M_W'(pay4_q.a[c*CHAN_W +: CHAN_W] - pay4_q.b[c*CHAN_W +: CHAN_W])
                   * M_W'(f4_q);
      end
    end
  end

  // ---- stage 6: blend, floor toward minus infinity
  logic [NUM_CHAN-1:0][CHAN_W-1:0] res_d;
  logic [M_W:0]                    m_up;
  logic                            v6_q;
  logic [NUM_CHAN-1:0][CHAN_W-1:0] res6_q;
  logic [TIME_BITS-1:0]            t6_q;

  always_comb begin
    m_up = '0;
    for (int c = 0; c < NUM_CHAN; c++) begin
      m_up = (M_W+1)'(m5_q[c]) + (M_W+1)'((1 << FRAC_BITS) - 1);
      if (pay5_q.empty) begin
        res_d[c] = '0;
      end else if (ge5_q[c]) begin
        res_d[c] = pay5_q.a[c*CHAN_W +: CHAN_W] + m5_q[c][FRAC_BITS +: CHAN_W];
      end else begin
        res_d[c] = pay5_q.a[c*CHAN_W +: CHAN_W] - m_up[FRAC_BITS +: CHAN_W];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res6_q <= res_d;
    t6_q   <= pay5_q.t;
  end

  assign valid_o = v6_q;
  assign res_o   = res6_q;
  assign t_o     = t6_q;

endmodule

>>> design/keyframe_sky_interpolator_unit.sv
// ----------------------------------------------------------------------------
// keyframe_sky_interpolator_unit - keyframe sky color and light interpolator
// Two keyframe tracks blended by smoothstep, plus a table-driven sun vector.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on start_i with func_i, key_index_i, time_value_i and
//   value_a_i..value_f_i; a request is taken at an edge where start_i is high
//   and busy_o is low. busy_o stays low: one request is taken every cycle.
//   Write requests load one key of the color or brightness track and give no
//   result. A query gives one result on the output ports, marked by strobe_o
//   for exactly one cycle. The query passes through the input register, the
//   search and table read, the span stage, the 16-stage span divider (one
//   quotient bit per stage) and the smoothstep, blend and output stages.
//   Requests flow through the pipeline in order, so writes and queries may
//   be mixed freely; a query sees every write accepted before it.
//   The key counts are written over the cfg_* channel, which is always ready;
//   write them only while no query is in flight.
//   Reset clears the pipeline and sets the counts to 7 and 4. The key tables
//   are not cleared and must be written before they are used.
//   The receiver cannot stall: each result is valid for its strobe cycle only.
// ----------------------------------------------------------------------------
module keyframe_sky_interpolator_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [1:0]                        func_i,
  input  logic [kski_pkg::KEY_IDX_W-1:0]    key_index_i,
  input  logic [kski_pkg::TIME_BITS-1:0]    time_value_i,
  input  logic [kski_pkg::CHAN_W-1:0]       value_a_i,
  input  logic [kski_pkg::CHAN_W-1:0]       value_b_i,
  input  logic [kski_pkg::CHAN_W-1:0]       value_c_i,
  input  logic [kski_pkg::CHAN_W-1:0]       value_d_i,
  input  logic [kski_pkg::CHAN_W-1:0]       value_e_i,
  input  logic [kski_pkg::CHAN_W-1:0]       value_f_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic                              cfg_index_i,
  input  logic [kski_pkg::CNT_W-1:0]        cfg_data_i,
  output logic                              strobe_o,
  output logic [kski_pkg::CHAN_W-1:0]       sky_red_o,
  output logic [kski_pkg::CHAN_W-1:0]       sky_green_o,
  output logic [kski_pkg::CHAN_W-1:0]       sky_blue_o,
  output logic [kski_pkg::CHAN_W-1:0]       fog_red_o,
  output logic [kski_pkg::CHAN_W-1:0]       fog_green_o,
  output logic [kski_pkg::CHAN_W-1:0]       fog_blue_o,
  output logic [kski_pkg::CHAN_W-1:0]       sky_level_o,
  output logic [kski_pkg::CHAN_W-1:0]       ambient_out_o,
  output logic [kski_pkg::CHAN_W-1:0]       sun_strength_o,
  output logic signed [kski_pkg::CHAN_W-1:0] sun_x_o,
  output logic signed [kski_pkg::CHAN_W-1:0] sun_y_o,
  output logic signed [kski_pkg::CHAN_W-1:0] sun_z_o
);
  import kski_pkg::*;

  localparam int RES_LAT = DIV_STAGES + 8;

  logic accept;
  func_e func;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;
  assign func        = func_e'(func_i);

  // ---- key count registers
  logic [CNT_W-1:0] color_cnt_q;
  logic [CNT_W-1:0] bright_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_cnt_q  <= CNT_W'(7);
      bright_cnt_q <= CNT_W'(4);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_COLOR_CNT:  color_cnt_q  <= cfg_data_i;
        REG_BRIGHT_CNT: bright_cnt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---- request decode into the input register
  trk_ctl_t col_ctl_d;
  trk_ctl_t bri_ctl_d;
  trk_ctl_t col_ctl_q;
  trk_ctl_t bri_ctl_q;

  always_comb begin
    col_ctl_d = '0;
    bri_ctl_d = '0;
    unique case (func)
      FUNC_WR_COLOR:  col_ctl_d.wr = accept;
      FUNC_WR_BRIGHT: bri_ctl_d.wr = accept;
      FUNC_QUERY: begin
        col_ctl_d.query = accept;
        bri_ctl_d.query = accept;
      end
      default: ;
    endcase
  end

  logic [KEY_IDX_W-1:0] idx0_q;
  logic [TIME_BITS-1:0] t0_q;
  logic [VAL_W-1:0]     vals0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_ctl_q <= '0;
      bri_ctl_q <= '0;
    end else begin
      col_ctl_q <= col_ctl_d;
      bri_ctl_q <= bri_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx0_q  <= key_index_i;
    t0_q    <= time_value_i;
    vals0_q <= {value_f_i, value_e_i, value_d_i, value_c_i, value_b_i, value_a_i};
  end

  // ---- tracks
  logic                            col_vld;
  logic                            bri_vld;
  logic [NUM_CHAN-1:0][CHAN_W-1:0] col_res;
  logic [NUM_CHAN-1:0][CHAN_W-1:0] bri_res;
  logic [TIME_BITS-1:0]            col_t;
  logic [TIME_BITS-1:0]            bri_t;

  kski_track u_color (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (col_ctl_q),
    .cnt_i   (color_cnt_q),
    .idx_i   (idx0_q),
    .t_i     (t0_q),
    .vals_i  (vals0_q),
    .valid_o (col_vld),
    .res_o   (col_res),
    .t_o     (col_t)
  );

  kski_track u_bright (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (bri_ctl_q),
    .cnt_i   (bright_cnt_q),
    .idx_i   (idx0_q),
    .t_i     (t0_q),
    .vals_i  (vals0_q),
    .valid_o (bri_vld),
    .res_o   (bri_res),
    .t_o     (bri_t)
  );

  // ---- sun direction lookup: arc for the first half day, else fixed
  logic [SUN_IDX_W-1:0] sun_idx;

  assign sun_idx = col_t[TIME_BITS-1] ? SUN_IDX_W'(SUN_FIXED_IDX)
                                      : SUN_IDX_W'(col_t[TIME_BITS-1 -: SINE_BITS]);

  // ---- output register
  logic                            strobe_q;
  logic [NUM_CHAN-1:0][CHAN_W-1:0] col_q;
  logic [2:0][CHAN_W-1:0]          bri_q;
  logic [SUN_W-1:0]                sun_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= col_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q <= col_res;
    bri_q <= bri_res[2:0];
    sun_q <= SUN_TAB[sun_idx];
  end

  assign strobe_o       = strobe_q;
  assign sky_red_o      = col_q[0];
  assign sky_green_o    = col_q[1];
  assign sky_blue_o     = col_q[2];
  assign fog_red_o      = col_q[3];
  assign fog_green_o    = col_q[4];
  assign fog_blue_o     = col_q[5];
  assign sky_level_o    = bri_q[0];
  assign ambient_out_o  = bri_q[1];
  assign sun_strength_o = bri_q[2];
  assign sun_x_o        = signed'(sun_q[3*CHAN_W-1 -: CHAN_W]);
  assign sun_y_o        = signed'(sun_q[2*CHAN_W-1 -: CHAN_W]);
  assign sun_z_o        = signed'(sun_q[CHAN_W-1:0]);

`ifndef NO_ASSERTIONS
  // a query gives its strobe after the fixed pipeline latency
  a_query_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && func == FUNC_QUERY) |-> ##RES_LAT strobe_o)
    else $error("query result strobe missing");

  // both tracks stay in lockstep
  a_tracks_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_vld == bri_vld && (!col_vld || col_t == bri_t))
    else $error("track pipelines out of step");

  // normalized sun components stay within unit range
  a_sun_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (sun_x_o <= 16384 && sun_x_o >= -16384 &&
                  sun_y_o <= 16384 && sun_y_o >= -16384 &&
                  sun_z_o <= 16384 && sun_z_o >= -16384))
    else $error("sun direction out of range");
`endif

endmodule

>>> tb/sv/keyframe_sky_interpolator_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_sky_interpolator_unit_test - self-checking bench of the sky unit
// Loads both keyframe tracks, runs a directed table and then random write
// and query requests under several key counts. Each query result is checked
// against an in-bench model of the smoothstep blend and the sun vector.
// ----------------------------------------------------------------------------
module keyframe_sky_interpolator_unit_test;
  import kski_pkg::*;

  localparam int  RESET_CYCLES = 11;
  localparam int  DRAIN_CYCLES = 40;
  localparam int  CYCLE_LIMIT  = 200000;
  localparam int  RANDOM_REQS  = 1250;
  localparam int  TIME_WRAP    = 65536;

  // one result: sky rgb, fog rgb, level, ambient, sun strength, sun xyz
  typedef logic [11:0][15:0] sky_vec_t;
  typedef logic [5:0][15:0]  six_val_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  // directed stimulus row; a config row sets both key counts
  typedef struct {
    row_kind_e       kind;
    func_e           func;
    logic [2:0]      idx;
    logic [15:0]     tod;
    six_val_t        val;
    logic [8:0]      mask;
    logic [8:0][15:0] typed;
    logic [3:0]      color_cnt;
    logic [3:0]      bright_cnt;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic [1:0] func_i = '0;
  logic [KEY_IDX_W-1:0] key_index_i = '0;
  logic [TIME_BITS-1:0] time_value_i = '0;
  logic [CHAN_W-1:0] value_a_i = '0, value_b_i = '0, value_c_i = '0;
  logic [CHAN_W-1:0] value_d_i = '0, value_e_i = '0, value_f_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = 1'b0;
  logic [CNT_W-1:0] cfg_data_i = '0;
  logic strobe_o;
  logic [CHAN_W-1:0] sky_red_o, sky_green_o, sky_blue_o;
  logic [CHAN_W-1:0] fog_red_o, fog_green_o, fog_blue_o;
  logic [CHAN_W-1:0] sky_level_o, ambient_out_o, sun_strength_o;
  logic signed [CHAN_W-1:0] sun_x_o, sun_y_o, sun_z_o;

  // model state
  logic [15:0] color_time [8];
  six_val_t    color_key [8];
  logic [15:0] bright_time [8];
  six_val_t    bright_key [8];
  int          color_cnt = 7;
  int          bright_cnt = 4;

  sky_vec_t    pending_sky [$];
  int          errors = 0;
  int          cycles = 0;
  stim_row_t   dir_tab [$];

  string chan_name [12] = '{"sky_red", "sky_green", "sky_blue", "fog_red", "fog_green",
                            "fog_blue", "sky_level", "ambient_out", "sun_strength",
                            "sun_x", "sun_y", "sun_z"};

  keyframe_sky_interpolator_unit dut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // ---------------------------------------------------------------- model
  // bracket search and smoothstep weight of one track
  function automatic void span_weight(input logic [15:0] tm [8], input int cnt,
                                      input logic [15:0] tod, output int lo,
                                      output int hi, output longint unsigned w,
                                      output bit has_keys);
    int n;
    int nx;
    bit found;
    longint unsigned t0, t1, lt, span, s;
    n = (cnt > MAX_KEYS) ? MAX_KEYS : cnt;
    w = 0;
    lo = 0;
    hi = 0;
    has_keys = (n != 0);
    if (n <= 1) return;
    nx = 0;
    found = 0;
    for (int i = 0; i < n; i++) begin
      if (!found && tm[i] > tod) begin
        nx = i;
        found = 1;
      end
    end
    hi = nx;
    lo = (nx == 0) ? n - 1 : nx - 1;
    t0 = tm[lo];
    t1 = tm[hi];
    if (t1 <= t0) t1 += TIME_WRAP;
    lt = (tod < t0) ? tod + TIME_WRAP : tod;
    span = t1 - t0;
    if (span * 10000 <= TIME_WRAP) return;
    s = ((lt - t0) << 16) / span;
    if (s > 65536) s = 65536;
    w = (s * s * (196608 - 2 * s)) >> 32;
  endfunction

  function automatic logic [15:0] lerp_chan(longint unsigned a, longint unsigned b,
                                            longint unsigned w);
    if (b >= a) return 16'(a + (((b - a) * w) >> 16));
    return 16'(a - (((a - b) * w + 65535) >> 16));
  endfunction

  // sine of a quarter-turn fraction in Q30, Taylor series, Q14 out
  function automatic longint quarter_sine(logic [63:0] r);
    logic [63:0] x, x2, term;
    longint acc;
    x = (r * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    term = x;
    acc = longint'(x);
    for (int k = 1; k <= 6; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      acc = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    acc = longint'((64'(acc) + 64'd32768) >> 16);
    return (acc > 16384) ? 16384 : acc;
  endfunction

  function automatic longint turn_sine(logic [63:0] ph);
    logic [63:0] r;
    longint s;
    r = ph & 64'h3FFF_FFFF;
    if (ph[30]) r = 64'h4000_0000 - r;
    s = quarter_sine(r);
    return ph[31] ? -s : s;
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] cand;
    res = 0;
    for (int b = 31; b >= 0; b--) begin
      cand = res | (64'd1 << b);
      if (cand * cand <= v) res = cand;
    end
    return res;
  endfunction

  // unit sun direction {x, y, z}
  function automatic void sun_vector(input logic [15:0] tod, output logic [2:0][15:0] d);
    longint c [3];
    logic [63:0] ph, len, m, q;
    if (tod < 16'h8000) begin
      ph = 64'(tod >> 8) << 24;
      c[0] = -turn_sine((ph + 64'h4000_0000) & 64'hFFFF_FFFF);
      c[1] = turn_sine(ph) + 1638;
    end else begin
      c[0] = 3277;
      c[1] = 13107;
    end
    c[2] = 4915;
    len = root_floor(64'(c[0] * c[0] + c[1] * c[1] + c[2] * c[2]));
    if (len == 0) len = 1;
    for (int k = 0; k < 3; k++) begin
      m = (c[k] < 0) ? 64'(-c[k]) : 64'(c[k]);
      q = (m * 64'd16384 + len / 2) / len;
      if (q > 64'd16384) q = 64'd16384;
      d[k] = (c[k] < 0) ? 16'(64'h10000 - q) : 16'(q);
    end
  endfunction

  function automatic sky_vec_t sky_at(logic [15:0] tod);
    sky_vec_t r;
    int lo, hi;
    longint unsigned w;
    bit has_keys;
    logic [2:0][15:0] d;
    r = '0;
    span_weight(color_time, color_cnt, tod, lo, hi, w, has_keys);
    if (has_keys) begin
      for (int k = 0; k < 6; k++) r[k] = lerp_chan(color_key[lo][k], color_key[hi][k], w);
    end
    span_weight(bright_time, bright_cnt, tod, lo, hi, w, has_keys);
    if (has_keys) begin
      for (int k = 0; k < 3; k++) r[6 + k] = lerp_chan(bright_key[lo][k], bright_key[hi][k], w);
    end
    sun_vector(tod, d);
    for (int k = 0; k < 3; k++) r[9 + k] = d[k];
    return r;
  endfunction

  // ---------------------------------------------------------------- driving
  task automatic issue_request(func_e f, logic [2:0] idx, logic [15:0] tod, six_val_t v,
                               logic [8:0] mask, logic [8:0][15:0] typed, bit may_idle);
    sky_vec_t e;
    if (may_idle && $urandom_range(99) < 8) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i      <= 1'b1;
    func_i       <= f;
    key_index_i  <= idx;
    time_value_i <= tod;
    value_a_i    <= v[0];
    value_b_i    <= v[1];
    value_c_i    <= v[2];
    value_d_i    <= v[3];
    value_e_i    <= v[4];
    value_f_i    <= v[5];
    do @(posedge clk_i); while (busy_o);
    // request taken at this edge
    case (f)
      FUNC_WR_COLOR: begin
        color_time[idx] = tod;
        color_key[idx]  = v;
      end
      FUNC_WR_BRIGHT: begin
        bright_time[idx] = tod;
        bright_key[idx]  = {48'h0, v[2:0]};
      end
      FUNC_QUERY: begin
        e = sky_at(tod);
        for (int k = 0; k < 9; k++) begin
          if (mask[k]) e[k] = typed[k];
        end
        pending_sky = {pending_sky, e};
      end
      default: ;
    endcase
  endtask

  task automatic drain_pipe();
    start_i <= 1'b0;
    while (pending_sky.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // pipeline must be empty before the counts change
  task automatic set_key_counts(logic [3:0] cc, logic [3:0] bc);
    drain_pipe();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_COLOR_CNT;
    cfg_data_i  <= cc;
    do @(posedge clk_i); while (!cfg_ready_o);
    color_cnt = cc;
    cfg_index_i <= REG_BRIGHT_CNT;
    cfg_data_i  <= bc;
    do @(posedge clk_i); while (!cfg_ready_o);
    bright_cnt = bc;
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------- checking
  always @(posedge clk_i) begin
    sky_vec_t got;
    sky_vec_t want;
    if (rst_ni && strobe_o) begin
      got = {sun_z_o, sun_y_o, sun_x_o, sun_strength_o, ambient_out_o, sky_level_o,
             fog_blue_o, fog_green_o, fog_red_o, sky_blue_o, sky_green_o, sky_red_o};
      if (pending_sky.size() == 0) begin
        report_mismatch("result with no query outstanding");
      end else begin
        want = pending_sky.pop_front();
        for (int k = 0; k < 12; k++) begin
          if (got[k] !== want[k]) begin
            report_mismatch($sformatf("%s got %h want %h", chan_name[k], got[k], want[k]));
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- table rows
  function automatic six_val_t v6(int a, int b, int c, int d, int e, int f);
    six_val_t r;
    r = {16'(f), 16'(e), 16'(d), 16'(c), 16'(b), 16'(a)};
    return r;
  endfunction

  function automatic stim_row_t req_row(func_e f, int idx, int tod, six_val_t v,
                                        logic [8:0] mask, six_val_t tc, six_val_t tb);
    stim_row_t r;
    r.kind = ROW_REQ;
    r.func = f;
    r.idx = 3'(idx);
    r.tod = 16'(tod);
    r.val = v;
    r.mask = mask;
    for (int k = 0; k < 6; k++) r.typed[k] = tc[k];
    for (int k = 0; k < 3; k++) r.typed[6 + k] = tb[k];
    r.color_cnt = '0;
    r.bright_cnt = '0;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(int cc, int bc);
    stim_row_t r;
    r = req_row(FUNC_RSVD, 0, 0, '0, '0, '0, '0);
    r.kind = ROW_CFG;
    r.color_cnt = 4'(cc);
    r.bright_cnt = 4'(bc);
    return r;
  endfunction

  // append one row to the directed table
  function automatic void add_row(stim_row_t r);
    dir_tab = {dir_tab, r};
  endfunction

  initial begin
    six_val_t k0c, k0b, rv;
    stim_row_t row;
    int pick;
    int ph;
    logic [15:0] tod;
    logic [2:0] idx;
    func_e f;

    k0c = v6(16'hFFFF, 0, 16'h8000, 16'h7FFF, 1, 16'hFFFE);
    k0b = v6(16'hFFFF, 0, 16'h8000, 0, 0, 0);

    // keys: color 0 and 1 are four ticks apart (short span), the rest sorted
    add_row(cfg_row(0, 0));
    add_row(req_row(FUNC_WR_COLOR, 0, 16'h0000, k0c, '0, '0, '0));
    add_row(req_row(FUNC_WR_COLOR, 1, 16'h0004,
                    v6(0, 16'hFFFF, 16'h7FFF, 16'h8000, 16'hFFFE, 1), '0, '0, '0));
    for (int i = 2; i < 8; i++) begin
      add_row(req_row(FUNC_WR_COLOR, i, i * 16'h2000 - (i == 7 ? 16'h0FFF : 0),
                      v6(i * 9000, 65535 - i * 7000, i * 3000, 40000, i * 111,
                         (i % 2) ? 65535 : 0), '0, '0, '0));
    end
    add_row(req_row(FUNC_WR_BRIGHT, 0, 16'h0000, k0b, '0, '0, '0));
    for (int i = 1; i < 8; i++) begin
      add_row(req_row(FUNC_WR_BRIGHT, i, i * 16'h2000,
                      v6(65535 - i * 9000, i * 8000, (i % 2) ? 0 : 65535,
                         16'hFFFF, 16'hFFFF, 16'hFFFF), '0, '0, '0));
    end
    // unused function code is dropped
    add_row(req_row(FUNC_RSVD, 7, 16'hFFFF, v6(1, 2, 3, 4, 5, 6), '0, '0, '0));
    // empty tracks give zero channels
    add_row(req_row(FUNC_QUERY, 0, 16'h8000, '0, 9'h1FF, '0, '0));
    // single key returns that key
    add_row(cfg_row(1, 1));
    add_row(req_row(FUNC_QUERY, 0, 16'h1234, '0, 9'h1FF, k0c, k0b));
    // count above the table size, short color span returns the earlier key
    add_row(cfg_row(15, 8));
    add_row(req_row(FUNC_QUERY, 0, 16'h0002, '0, 9'h03F, k0c, '0));
    add_row(req_row(FUNC_QUERY, 0, 16'h0000, '0, '0, '0, '0));
    add_row(req_row(FUNC_QUERY, 0, 16'hFFFF, '0, '0, '0, '0));
    add_row(req_row(FUNC_QUERY, 0, 16'h7FFF, '0, '0, '0, '0));
    add_row(req_row(FUNC_QUERY, 0, 16'h4000, '0, '0, '0, '0));
    add_row(req_row(FUNC_QUERY, 0, 16'hF100, '0, '0, '0, '0));

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      if (row.kind == ROW_CFG) begin
        set_key_counts(row.color_cnt, row.bright_cnt);
      end else begin
        issue_request(row.func, row.idx, row.tod, row.val, row.mask, row.typed, 1'b1);
      end
    end

    // random requests; counts change every 250 requests with a full drain
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 250 == 0) begin
        ph = n / 250;
        case (ph)
          0: set_key_counts(8, 8);
          1: set_key_counts(0, 15);
          2: set_key_counts(15, 1);
          3: set_key_counts(1, 0);
          default: set_key_counts(4'($urandom_range(15)), 4'($urandom_range(15)));
        endcase
      end
      rv = {16'($urandom), 16'($urandom), 16'($urandom),
            16'($urandom), 16'($urandom), 16'($urandom)};
      idx = 3'($urandom_range(7));
      pick = $urandom_range(99);
      if (pick < 55) begin
        f = FUNC_QUERY;
        tod = 16'($urandom);
        if ($urandom_range(4) == 0) tod = color_time[idx] + 16'($urandom_range(3));
        if ($urandom_range(9) == 0) tod = bright_time[idx];
      end else if (pick < 93) begin
        f = (pick < 74) ? FUNC_WR_COLOR : FUNC_WR_BRIGHT;
        // mostly keep each track sorted, sometimes not
        if ($urandom_range(99) < 85) tod = {idx, 13'($urandom)};
        else tod = 16'($urandom);
      end else begin
        f = FUNC_RSVD;
        tod = 16'($urandom);
      end
      issue_request(f, idx, tod, rv, '0, '0, !(n >= 400 && n < 700));
    end

    start_i <= 1'b0;
    while (pending_sky.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
